/* hw/rtl/kmp_pkg.sv */
`default_nettype none

package kmp_pkg;

  localparam int CHAR_W    = 8;
  localparam int OFS_OUT_W = 32;

  localparam logic REQ_PATTERN = 1'b0;
  localparam logic REQ_TEXT    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD_RD,
    ST_BUILD_STEP,
    ST_TEXT_STEP
  } state_t;

  // Datapath conditions seen by the sequencer
  typedef struct packed {
    logic start_build;
    logic start_text;
    logic build_done;
    logic text_more;
    logic text_hold;
  } status_t;

  // Sequencer commands to the datapath
  typedef struct packed {
    logic in_ready;
    logic build_rd;
    logic build_step;
    logic text_step;
  } ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/kmp_if.sv */
`default_nettype none

interface kmp_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [kmp_pkg::CHAR_W-1:0]  char_value;
  logic                        is_last;

  modport source (output valid, output req_type, output char_value, output is_last,
                  input ready);
  modport sink (input valid, input req_type, input char_value, input is_last,
                output ready);
endinterface

interface kmp_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [kmp_pkg::OFS_OUT_W-1:0]  match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink (input valid, input found, input match_offset, output ready);
endinterface

`default_nettype wire

/* hw/rtl/kmp_seq.sv */
`default_nettype none

module kmp_seq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire kmp_pkg::status_t status,
  output kmp_pkg::ctl_t         ctl
);

  kmp_pkg::state_t state;
  kmp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kmp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      kmp_pkg::ST_IDLE: begin
        if (status.start_build) begin
          state_next = kmp_pkg::ST_BUILD_RD;
        end else if (status.start_text) begin
          state_next = kmp_pkg::ST_TEXT_STEP;
        end
      end
      kmp_pkg::ST_BUILD_RD: begin
        state_next = kmp_pkg::ST_BUILD_STEP;
      end
      kmp_pkg::ST_BUILD_STEP: begin
        if (status.build_done) begin
          state_next = kmp_pkg::ST_IDLE;
        end
      end
      kmp_pkg::ST_TEXT_STEP: begin
        if (!status.text_more && !status.text_hold) begin
          state_next = kmp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kmp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl.in_ready   = (state == kmp_pkg::ST_IDLE);
    ctl.build_rd   = (state == kmp_pkg::ST_BUILD_RD);
    ctl.build_step = (state == kmp_pkg::ST_BUILD_STEP);
    ctl.text_step  = (state == kmp_pkg::ST_TEXT_STEP) && !status.text_hold;
  end

endmodule

`default_nettype wire

/* hw/rtl/kmp_substring_search_unit.sv */
// Pattern byte: taken in idle; a final byte that installs L >= 2 bytes adds a prefix-table
//   build (a read state, then a build step per table advance or fallback), ready low throughout.
// Text byte: an accept in idle, then a compare per table step (match plus fallbacks); the
//   final compare stalls while rsp still holds a beat, and rsp.valid rises the cycle after it.
//   Text dropped after a match is taken in idle with no compare.
// rst (synchronous) clears control and text state; pattern and prefix memories hold garbage.
`default_nettype none

module kmp_substring_search_unit #(
  parameter int MAX_PATTERN = 64,
  parameter int OFFSET_BITS = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  kmp_req_if.sink     req,
  kmp_rsp_if.source   rsp
);

  // Index width addresses the memories; length width also holds MAX_PATTERN itself.
  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int DW = (OFFSET_BITS > kmp_pkg::OFS_OUT_W) ? OFFSET_BITS : kmp_pkg::OFS_OUT_W;

  kmp_pkg::status_t status;
  kmp_pkg::ctl_t    ctl;

  kmp_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctl    (ctl)
  );

  // Storage: pattern bytes (two read ports) and prefix table (one read port).
  logic [kmp_pkg::CHAR_W-1:0] pattern_mem [MAX_PATTERN];
  logic [IW-1:0]              prefix_mem  [MAX_PATTERN];

  logic [kmp_pkg::CHAR_W-1:0] sdat_a;
  logic [kmp_pkg::CHAR_W-1:0] sdat_b;
  logic [IW-1:0]              pdat;

  // Control and text state
  logic [LW-1:0]          pattern_length;
  logic [LW-1:0]          load_count;
  logic [LW-1:0]          matched_length;
  logic [OFFSET_BITS-1:0] text_offset;
  logic                   match_reported;

  // Per-item working registers
  logic [OFFSET_BITS-1:0]     here;
  logic [kmp_pkg::CHAR_W-1:0] char_reg;
  logic                       last_reg;
  logic [IW-1:0]              bi;
  logic [IW-1:0]              bk;

  // Result register
  logic                          out_valid;
  logic                          out_found;
  logic [kmp_pkg::OFS_OUT_W-1:0] out_offset;

  logic acc;
  logic acc_pat;
  logic acc_txt;
  logic pat_wr;
  logic [LW-1:0] lc_inc;

  assign req.ready = ctl.in_ready;
  assign acc       = req.valid && req.ready;
  assign acc_pat   = acc && (req.req_type == kmp_pkg::REQ_PATTERN);
  assign acc_txt   = acc && (req.req_type == kmp_pkg::REQ_TEXT);
  assign pat_wr    = acc_pat && (load_count < LW'(MAX_PATTERN));
  assign lc_inc    = (load_count < LW'(MAX_PATTERN)) ? load_count + LW'(1) : load_count;

  // Table build step: compare pattern[k] with pattern[i], fall back on mismatch.
  logic          b_eq;
  logic          b_fall;
  logic [IW-1:0] knew;

  assign b_eq   = (sdat_a == sdat_b);
  assign b_fall = (bk != '0) && !b_eq;
  assign knew   = b_eq ? bk + IW'(1) : bk;

  // Text step: compare pattern[q] with the text byte.
  logic          len_zero;
  logic          t_eq;
  logic          t_fall;
  logic [LW-1:0] qn;
  logic          t_full;
  logic          need_result;
  logic          out_free;
  logic          result_fire;

  assign len_zero    = (pattern_length == '0);
  assign t_eq        = (sdat_a == char_reg);
  assign t_fall      = !len_zero && (matched_length != '0) && !t_eq;
  assign qn          = t_eq ? matched_length + LW'(1) : matched_length;
  assign t_full      = !len_zero && !t_fall && (qn == pattern_length);
  assign need_result = !t_fall && (t_full || last_reg);
  assign out_free    = !out_valid || rsp.ready;
  assign result_fire = ctl.text_step && need_result;

  always_comb begin
    status.start_build = acc_pat && req.is_last && (lc_inc > LW'(1));
    status.start_text  = acc_txt && !match_reported;
    status.build_done  = !b_fall && ((LW'(bi) + LW'(1)) == pattern_length);
    status.text_more   = t_fall;
    status.text_hold   = need_result && !out_free;
  end

  // Read addresses: the prefix port always looks one entry below port A.
  logic          rd_en;
  logic [IW-1:0] addr_a;
  logic [IW-1:0] addr_b;
  logic [IW-1:0] addr_p;

  always_comb begin
    rd_en  = 1'b0;
    addr_a = '0;
    addr_b = bi;
    if (ctl.build_rd) begin
      rd_en  = 1'b1;
      addr_a = bk;
      addr_b = bi;
    end else if (ctl.build_step) begin
      rd_en  = !status.build_done;
      addr_a = b_fall ? pdat : knew;
      addr_b = b_fall ? bi : bi + IW'(1);
    end else if (status.start_text) begin
      rd_en  = 1'b1;
      addr_a = matched_length[IW-1:0];
    end else if (ctl.text_step && t_fall) begin
      rd_en  = 1'b1;
      addr_a = pdat;
    end
    addr_p = addr_a - IW'(1);
  end

  // Prefix write: entry zero on the final pattern byte, entry i on each build advance.
  logic          pre_we;
  logic [IW-1:0] pre_waddr;
  logic [IW-1:0] pre_wdata;

  assign pre_we    = (acc_pat && req.is_last) || (ctl.build_step && !b_fall);
  assign pre_waddr = ctl.build_step ? bi : '0;
  assign pre_wdata = ctl.build_step ? knew : '0;

  always_ff @(posedge clk) begin
    if (pat_wr) begin
      pattern_mem[load_count[IW-1:0]] <= req.char_value;
    end
    if (pre_we) begin
      prefix_mem[pre_waddr] <= pre_wdata;
    end
    if (rd_en) begin
      sdat_a <= pattern_mem[addr_a];
      sdat_b <= pattern_mem[addr_b];
      pdat   <= prefix_mem[addr_p];
    end
  end

  // Build indices: start at i = 1, k = 0; advance or fall back one step a cycle.
  always_ff @(posedge clk) begin
    if (status.start_build) begin
      bi <= IW'(1);
      bk <= '0;
    end else if (ctl.build_step) begin
      if (b_fall) begin
        bk <= pdat;
      end else begin
        bk <= knew;
        bi <= bi + IW'(1);
      end
    end
  end

  // Latch the text byte and its offset when a byte is accepted for search.
  always_ff @(posedge clk) begin
    if (status.start_text) begin
      here     <= text_offset;
      char_reg <= req.char_value;
      last_reg <= req.is_last;
    end
  end

  // Pattern load and text state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      load_count     <= '0;
      matched_length <= '0;
      text_offset    <= '0;
      match_reported <= 1'b0;
    end else if (acc_pat) begin
      // Any pattern byte retires the old pattern and clears the text state
      matched_length <= '0;
      text_offset    <= '0;
      match_reported <= 1'b0;
      if (req.is_last) begin
        pattern_length <= lc_inc;
        load_count     <= '0;
      end else begin
        pattern_length <= '0;
        load_count     <= lc_inc;
      end
    end else if (acc_txt) begin
      if (match_reported) begin
        // Drop text after a match; the final byte rearms the search
        if (req.is_last) begin
          matched_length <= '0;
          text_offset    <= '0;
          match_reported <= 1'b0;
        end
      end else if (!(&text_offset)) begin
        text_offset <= text_offset + OFFSET_BITS'(1);
      end
    end else if (ctl.text_step) begin
      if (t_fall) begin
        matched_length <= LW'(pdat);
      end else if (t_full) begin
        matched_length <= '0;
        if (last_reg) begin
          text_offset <= '0;
        end else begin
          match_reported <= 1'b1;
        end
      end else begin
        if (last_reg) begin
          matched_length <= '0;
          text_offset    <= '0;
          match_reported <= 1'b0;
        end else begin
          matched_length <= len_zero ? '0 : qn;
        end
      end
    end
  end

  // Result register: start of the match, reduced to the output width.
  logic [DW-1:0] start_pos;

  assign start_pos = DW'(here) + DW'(1) - DW'(pattern_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_fire) begin
      out_found  <= t_full;
      out_offset <= t_full ? start_pos[kmp_pkg::OFS_OUT_W-1:0] : '0;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.found        = out_found;
  assign rsp.match_offset = out_offset;

  // The matched length never reaches the pattern length between bytes.
  a_match_below_len: assert property (@(posedge clk) disable iff (rst)
    (pattern_length != '0) |-> (matched_length < pattern_length))
    else $error("matched length not below pattern length");

  // After a reported match no partial match is carried.
  a_reported_clear: assert property (@(posedge clk) disable iff (rst)
    match_reported |-> (matched_length == '0))
    else $error("partial match kept after report");

  // The build always compares a prefix end below the current index.
  a_build_k_below_i: assert property (@(posedge clk) disable iff (rst)
    ctl.build_step |-> (bk < bi))
    else $error("prefix build index order broken");

  // A miss result carries a zero offset.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.found) |-> (rsp.match_offset == '0))
    else $error("nonzero offset on miss");

endmodule

`default_nettype wire

/* tb/tb_kmp_substring_search_unit.sv */
`default_nettype none

module tb_kmp_substring_search_unit;
  import kmp_pkg::*;

  // Narrow offset counter so that saturation is reachable with short texts.
  localparam int MAX_PAT     = 64;
  localparam int OFS_BITS    = 8;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 300;
  localparam int N_ITEMS     = 1500;
  localparam int IDLE_PCT    = 26;

  typedef struct {
    logic              req_type;
    logic [CHAR_W-1:0] char_value;
    logic              is_last;
    bit                drain_first;  // hold this beat until every result is back
  } search_beat_t;

  typedef struct {
    logic                 found;
    logic [OFS_OUT_W-1:0] match_offset;
  } search_result_t;

  logic clk;
  logic rst;

  kmp_req_if req_ch ();
  kmp_rsp_if rsp_ch ();

  kmp_substring_search_unit #(
    .MAX_PATTERN (MAX_PAT),
    .OFFSET_BITS (OFS_BITS)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // ---------------------------------------------------------------------------
  // Search predictor: pattern memory, failure table and text-scan state.
  // ---------------------------------------------------------------------------
  logic [CHAR_W-1:0]   pat_mem  [MAX_PAT];
  logic [6:0]          fail_tab [MAX_PAT];
  logic [6:0]          pat_len;
  logic [6:0]          fill_cnt;
  logic [6:0]          cur_match;
  logic [OFS_BITS-1:0] text_pos;
  logic                hit_seen;

  search_beat_t   pending_beats [$];
  search_result_t expected_outcomes [$];

  int unsigned results_due;    // written by the driver only
  int unsigned results_seen;   // written by the monitor only, nonblocking
  int unsigned beats_accepted;
  int unsigned stall_cycles;
  int unsigned errors;

  // Stimulus helpers: current pattern and the alphabet used to build text.
  logic [CHAR_W-1:0] cur_pat [$];
  logic [CHAR_W-1:0] alpha [$];
  bit                full_range;

  function automatic void clear_text();
    cur_match = '0;
    text_pos  = '0;
    hit_seen  = 1'b0;
  endfunction

  function automatic void post_outcome(logic found, logic [OFS_OUT_W-1:0] ofs);
    search_result_t r;
    r.found        = found;
    r.match_offset = ofs;
    expected_outcomes.push_back(r);
    results_due++;
  endfunction

  // Advance the predictor by one accepted beat and queue what it must produce.
  function automatic void predict_search(search_beat_t b);
    logic [6:0]          k;
    logic [OFS_BITS-1:0] here;
    if (b.req_type == REQ_PATTERN) begin
      // Any pattern byte retires the installed pattern and the text scan.
      pat_len = '0;
      clear_text();
      if (fill_cnt < MAX_PAT) begin
        pat_mem[fill_cnt] = b.char_value;
        fill_cnt++;
      end
      if (b.is_last) begin
        pat_len  = fill_cnt;
        fill_cnt = '0;
        // Build the failure table over the installed bytes.
        k = '0;
        fail_tab[0] = '0;
        for (int i = 1; i < pat_len; i++) begin
          while (k != 0 && pat_mem[k] != pat_mem[i]) k = fail_tab[k-1];
          if (pat_mem[k] == pat_mem[i]) k++;
          fail_tab[i] = k;
        end
      end
      return;
    end
    // After the first hit, drop text until its final byte.
    if (hit_seen) begin
      if (b.is_last) clear_text();
      return;
    end
    here = text_pos;
    if (text_pos != '1) text_pos++;
    if (pat_len != 0) begin
      k = cur_match;
      while (k != 0 && pat_mem[k] != b.char_value) k = fail_tab[k-1];
      if (pat_mem[k] == b.char_value) k++;
      if (k == pat_len) begin
        post_outcome(1'b1, OFS_OUT_W'(here) - OFS_OUT_W'(pat_len) + 1);
        cur_match = '0;
        if (b.is_last) clear_text();
        else hit_seen = 1'b1;
        return;
      end
      cur_match = k;
    end
    if (b.is_last) begin
      post_outcome(1'b0, '0);
      clear_text();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  task automatic add_beat(logic t, logic [CHAR_W-1:0] c, logic l, bit d = 1'b0);
    search_beat_t b;
    b.req_type    = t;
    b.char_value  = c;
    b.is_last     = l;
    b.drain_first = d;
    pending_beats.push_back(b);
  endtask

  function automatic logic [CHAR_W-1:0] pick_char();
    if (full_range) return CHAR_W'($urandom_range(255));
    return alpha[$urandom_range(alpha.size() - 1)];
  endfunction

  // Return a byte that does not occur in the current pattern.
  function automatic logic [CHAR_W-1:0] absent_char();
    logic [CHAR_W-1:0] c;
    bit                hit;
    c = CHAR_W'($urandom_range(255));
    for (int n = 0; n < 256; n++) begin
      hit = 1'b0;
      foreach (cur_pat[j]) if (cur_pat[j] == c) hit = 1'b1;
      if (!hit) return c;
      c++;
    end
    return c;
  endfunction

  task automatic queue_pattern(int len, bit drain, bit ends);
    logic [CHAR_W-1:0] c;
    cur_pat.delete();
    for (int i = 0; i < len; i++) begin
      c = pick_char();
      cur_pat.push_back(c);
      add_beat(REQ_PATTERN, c, ends && (i == len - 1), drain && (i == 0));
    end
  endtask

  // Build a text, optionally with the pattern planted in it. With at_end set,
  // fill with a byte foreign to the pattern and plant it at the very end.
  task automatic queue_text(int len, bit plant, bit at_end, bit ends);
    logic [CHAR_W-1:0] txt [$];
    logic [CHAR_W-1:0] filler;
    int                pos;
    int                plen;
    plen   = cur_pat.size();
    filler = absent_char();
    for (int i = 0; i < len; i++) txt.push_back(at_end ? filler : pick_char());
    if (plant && plen > 0 && len >= plen) begin
      pos = at_end ? len - plen : $urandom_range(len - plen);
      for (int j = 0; j < plen; j++) txt[pos+j] = cur_pat[j];
    end
    for (int i = 0; i < len; i++) add_beat(REQ_TEXT, txt[i], ends && (i == len - 1));
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Long quiet window: neither side idles while it is open.
  wire calm = (beats_accepted >= 600) && (beats_accepted < 900);

  // ---------------------------------------------------------------------------
  // Driver: present pending beats, predict on acceptance.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid      <= 1'b0;
      req_ch.req_type   <= REQ_PATTERN;
      req_ch.char_value <= '0;
      req_ch.is_last    <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_search(pending_beats[0]);
        void'(pending_beats.pop_front());
        beats_accepted <= beats_accepted + 1;
      end
      // Hold the beat while it is stalled; otherwise pick the next one.
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_beats.size() != 0 &&
            !(pending_beats[0].drain_first && results_due != results_seen) &&
            (calm || $urandom_range(99) >= IDLE_PCT)) begin
          req_ch.valid      <= 1'b1;
          req_ch.req_type   <= pending_beats[0].req_type;
          req_ch.char_value <= pending_beats[0].char_value;
          req_ch.is_last    <= pending_beats[0].is_last;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: throttle ready, check every accepted result beat in order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    search_result_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen <= results_seen + 1;
        if (expected_outcomes.size() == 0) begin
          $error("unexpected result: found=%0d match_offset=%0d",
                 rsp_ch.found, rsp_ch.match_offset);
          errors++;
        end else begin
          want = expected_outcomes.pop_front();
          if (rsp_ch.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, rsp_ch.found);
            errors++;
          end
          if (rsp_ch.match_offset !== want.match_offset) begin
            $error("match_offset: expected %0d, actual %0d",
                   want.match_offset, rsp_ch.match_offset);
            errors++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: count cycles with no beat moving on either channel.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int r;
    int plen;
    int tlen;
    bit plant;
    bit at_end;

    // Drive every input to a known value before the first edge.
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_PATTERN;
    req_ch.char_value = '0;
    req_ch.is_last    = 1'b0;
    rsp_ch.ready      = 1'b0;
    results_due       = 0;
    results_seen      = 0;
    beats_accepted    = 0;
    stall_cycles      = 0;
    errors            = 0;
    pat_len           = '0;
    fill_cnt          = '0;
    clear_text();

    // Directed part.
    // Text with no pattern installed yet: no match possible.
    add_beat(REQ_TEXT, 8'h5A, 1'b1);
    // Pattern at both byte extremes, matched mid-text; later text is dropped.
    add_beat(REQ_PATTERN, 8'h00, 1'b0);
    add_beat(REQ_PATTERN, 8'hFF, 1'b1);
    add_beat(REQ_TEXT, 8'hFF, 1'b0);
    add_beat(REQ_TEXT, 8'h00, 1'b0);
    add_beat(REQ_TEXT, 8'hFF, 1'b0);
    add_beat(REQ_TEXT, 8'h00, 1'b0);
    add_beat(REQ_TEXT, 8'h12, 1'b1);
    // Match on the final text byte; wait for the pipe to drain first.
    add_beat(REQ_TEXT, 8'h00, 1'b0, 1'b1);
    add_beat(REQ_TEXT, 8'hFF, 1'b1);
    // Half-loaded pattern leaves no pattern in use: text must miss.
    add_beat(REQ_PATTERN, 8'hAB, 1'b0);
    add_beat(REQ_TEXT, 8'hAB, 1'b1);
    // Finish that load, then match.
    add_beat(REQ_PATTERN, 8'hAB, 1'b1);
    add_beat(REQ_TEXT, 8'hAB, 1'b0);
    add_beat(REQ_TEXT, 8'hAB, 1'b0);
    add_beat(REQ_TEXT, 8'h01, 1'b1);
    // Pattern byte in the middle of a text resets the scan.
    add_beat(REQ_TEXT, 8'hAB, 1'b0);
    add_beat(REQ_PATTERN, 8'h07, 1'b1);
    add_beat(REQ_TEXT, 8'h07, 1'b1);
    // Fallback through the failure table.
    add_beat(REQ_PATTERN, 8'h61, 1'b0);
    add_beat(REQ_PATTERN, 8'h61, 1'b0);
    add_beat(REQ_PATTERN, 8'h62, 1'b1);
    add_beat(REQ_TEXT, 8'h61, 1'b0);
    add_beat(REQ_TEXT, 8'h61, 1'b0);
    add_beat(REQ_TEXT, 8'h61, 1'b0);
    add_beat(REQ_TEXT, 8'h62, 1'b1);

    // Random part: sessions of one pattern followed by a few texts.
    while (pending_beats.size() < N_ITEMS) begin
      // Small alphabets give repeats and deep fallback chains.
      alpha.delete();
      full_range = ($urandom_range(99) < 20);
      repeat ($urandom_range(2, 4)) alpha.push_back(CHAR_W'($urandom_range(255)));

      r = $urandom_range(99);
      if (r < 4) plen = $urandom_range(MAX_PAT + 1, MAX_PAT + 6);   // truncated
      else if (r < 12) plen = $urandom_range(9, MAX_PAT);
      else plen = $urandom_range(1, 8);

      // Occasionally load part of a pattern, search with nothing installed,
      // then complete the load.
      if ($urandom_range(99) < 4) begin
        queue_pattern($urandom_range(1, 3), 1'b0, 1'b0);
        queue_text($urandom_range(1, 6), 1'b0, 1'b0, 1'b1);
      end
      queue_pattern(plen, $urandom_range(99) < 3, 1'b1);

      repeat ($urandom_range(1, 4)) begin
        r      = $urandom_range(99);
        at_end = (r < 1);
        plant  = at_end || ($urandom_range(99) < 60);
        if (at_end) tlen = $urandom_range(257, 266);               // past saturation
        else if (plant) tlen = cur_pat.size() + $urandom_range(0, 30);
        else tlen = $urandom_range(1, 40);
        queue_text(tlen, plant, at_end, 1'b1);
      end

      // Sometimes cut a text short; the next pattern byte interrupts it.
      if ($urandom_range(99) < 8) queue_text($urandom_range(1, 10), 1'b1, 1'b0, 1'b0);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Let everything drain, then give the block time to finish a build.
    while (pending_beats.size() != 0 || expected_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (expected_outcomes.size() != 0) begin
      $error("%0d expected results never arrived", expected_outcomes.size());
      errors++;
    end
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/kmp_pkg.sv
hw/rtl/kmp_if.sv
hw/rtl/kmp_seq.sv
hw/rtl/kmp_substring_search_unit.sv
tb/tb_kmp_substring_search_unit.sv
